// ----- hdl/assert_macros.svh -----
// assertion macros used by the deque top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   `ASSERT_PROP(label, clk, rst, (ante) |-> (cons))

`endif

// ----- hdl/kcd_pkg.sv -----
// shared types and codes of the keyed circular deque
package kcd_pkg;

   localparam int KEY_W    = 16;
   localparam int PAY_W    = 16;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam mode_type MODE_PUSH_BACK  = 3'd0;
   localparam mode_type MODE_PUSH_FRONT = 3'd1;
   localparam mode_type MODE_REMOVE     = 3'd2;
   localparam mode_type MODE_POP_FRONT  = 3'd3;
   localparam mode_type MODE_SEARCH     = 3'd4;
   localparam mode_type MODE_SUCCESSOR  = 3'd5;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_EMPTY    = 2'd1;
   localparam status_type ST_NOTFOUND = 2'd2;
   localparam status_type ST_FULL     = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } entry_type;

endpackage

// ----- hdl/keyed_circular_deque.sv -----
// keyed circular deque: top level with sequencer and slot memory
//
// req channel: one transaction carries an operation code in req_tuser and a
// key and payload in req_tdata. rsp channel: exactly one transaction per
// request, with the status in rsp_tuser and the key, payload and entry count
// in rsp_tdata. one request is worked on at a time; req_tready is high only
// while the sequencer is idle.
// the key scan and the gap closing after a removal each move one entry per
// cycle through the slot memory and the shared ring address unit; the number
// of entries held is at most DEPTH.
// the result sits in an output register; a new request is accepted while it
// waits, and a finished result is held until rsp_tready is seen, which stalls
// the sequencer only at its final step.
// reset clears the list to empty with head at slot 0; slot contents are not
// cleared since only live entries are ever read.
module keyed_circular_deque #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // entry_key, entry_payload
   input  logic [2:0]  req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // result_key, result_payload, entry_count
   output logic [1:0]  rsp_tuser   // status
);

   `include "assert_macros.svh"

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH-1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PUSH  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_GRAB  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]              state_ff, state_in;
   kcd_pkg::mode_type       mode_ff, mode_in;
   logic [kcd_pkg::KEY_W-1:0] key_ff, key_in;
   logic [kcd_pkg::PAY_W-1:0] pay_ff, pay_in;
   logic [AW-1:0]           head_ff, head_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           pos_ff, pos_in;
   logic                    pend_ff, pend_in;
   logic [AW-1:0]           a0_ff, a0_in;
   logic [AW-1:0]           a1_ff, a1_in;
   kcd_pkg::status_type     status_ff, status_in;
   kcd_pkg::entry_type      res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   kcd_pkg::status_type     rsp_status_ff, rsp_status_in;
   kcd_pkg::entry_type      rsp_entry_ff, rsp_entry_in;
   logic [kcd_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   kcd_pkg::entry_type      slot_mem [DEPTH];
   kcd_pkg::entry_type      rd_ff;

   logic [CW-1:0]           addr_pos;
   logic [AW-1:0]           addr_slot;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   kcd_pkg::entry_type      wr_data;
   logic                    rd_match;
   logic                    more;
   logic [AW-1:0]           head_inc;
   logic [AW-1:0]           head_dec;

   kcd_ring_addr #(
      .DEPTH(DEPTH)
   ) u_ring_addr (
      .head(head_ff),
      .pos (addr_pos),
      .slot(addr_slot)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_entry_ff.payload, rsp_entry_ff.key};

   assign head_inc = (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);
   assign head_dec = (head_ff == '0) ? LAST_SLOT : head_ff - AW'(1);
   assign rd_match = pend_ff && (rd_ff.key == key_ff);
   assign more     = (pos_ff < count_ff);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      pend_in       = pend_ff;
      a0_in         = a0_ff;
      a1_in         = a1_ff;
      status_in     = status_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_count_in  = rsp_count_ff;
      addr_pos      = '0;
      wr_en         = 1'b0;
      wr_addr       = a0_ff;
      wr_data       = rd_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in   = req_tuser;
               key_in    = req_tdata[15:0];
               pay_in    = req_tdata[31:16];
               status_in = kcd_pkg::ST_OK;
               res_in    = '0;
               pos_in    = '0;
               pend_in   = 1'b0;
               unique case (req_tuser) inside
                  kcd_pkg::MODE_PUSH_BACK, kcd_pkg::MODE_PUSH_FRONT: begin
                     if (count_ff == DEPTH_C) begin
                        status_in = kcd_pkg::ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_PUSH;
                     end
                  end
                  kcd_pkg::MODE_POP_FRONT: begin
                     if (count_ff == '0) begin
                        status_in = kcd_pkg::ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_GRAB;
                     end
                  end
                  kcd_pkg::MODE_REMOVE, kcd_pkg::MODE_SEARCH, kcd_pkg::MODE_SUCCESSOR: begin
                     if (count_ff == '0) begin
                        status_in = kcd_pkg::ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_PUSH: begin
            wr_en   = 1'b1;
            wr_data = '{key: key_ff, payload: pay_ff};
            if (mode_ff == kcd_pkg::MODE_PUSH_FRONT) begin
               wr_addr = head_dec;
               head_in = head_dec;
            end else begin
               addr_pos = count_ff;
               wr_addr  = addr_slot;
            end
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end
         S_SCAN: begin
            // the read issued here is the next entry, wrapping to the head at the end
            addr_pos = more ? pos_ff : '0;
            a1_in    = addr_slot;
            if (rd_match) begin
               if (mode_ff == kcd_pkg::MODE_REMOVE) begin
                  res_in = rd_ff;
                  if (more) begin
                     a0_in    = a1_ff;
                     pos_in   = pos_ff + CW'(1);
                     pend_in  = 1'b1;
                     state_in = S_SHIFT;
                  end else begin
                     count_in = count_ff - CW'(1);
                     state_in = S_DONE;
                  end
               end else if (mode_ff == kcd_pkg::MODE_SEARCH) begin
                  res_in   = rd_ff;
                  state_in = S_DONE;
               end else begin
                  state_in = S_GRAB;
               end
            end else if (more) begin
               pos_in  = pos_ff + CW'(1);
               pend_in = 1'b1;
            end else begin
               status_in = kcd_pkg::ST_NOTFOUND;
               state_in  = S_DONE;
            end
         end
         S_SHIFT: begin
            // move the entry read last cycle one place toward the head
            wr_en   = pend_ff;
            wr_addr = a0_ff;
            wr_data = rd_ff;
            if (more) begin
               addr_pos = pos_ff;
               a0_in    = a1_ff;
               a1_in    = addr_slot;
               pos_in   = pos_ff + CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end
         S_GRAB: begin
            res_in = rd_ff;
            if (mode_ff == kcd_pkg::MODE_POP_FRONT) begin
               head_in  = head_inc;
               count_in = count_ff - CW'(1);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_entry_in  = res_ff;
               rsp_count_in  = kcd_pkg::COUNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      pos_ff        <= pos_in;
      pend_ff       <= pend_in;
      a0_ff         <= a0_in;
      a1_ff         <= a1_in;
      status_ff     <= status_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_ff <= slot_mem[addr_slot];
   end

   `ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_C)
   `ASSERT_IMPLY(a_scan_pos, clock, reset, state_ff == S_SCAN, pos_ff <= count_ff)
   `ASSERT_IMPLY(a_shift_pend, clock, reset, state_ff == S_SHIFT, pend_ff && count_ff != '0)
   `ASSERT_IMPLY(a_full_status, clock, reset,
      state_ff == S_DONE && status_ff == kcd_pkg::ST_FULL, count_ff == DEPTH_C)
   `ASSERT_IMPLY(a_empty_status, clock, reset,
      state_ff == S_DONE && status_ff == kcd_pkg::ST_EMPTY, count_ff == '0)

endmodule

// ----- hdl/kcd_ring_addr.sv -----
// ring address unit: slot of a logical position, (head + pos) mod depth
module kcd_ring_addr #(
   parameter int DEPTH = 16
) (
   input  logic [$clog2(DEPTH)-1:0]   head,
   input  logic [$clog2(DEPTH+1)-1:0] pos,
   output logic [$clog2(DEPTH)-1:0]   slot
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   localparam logic [CW:0] DEPTH_S = (CW+1)'(DEPTH);

   logic [CW:0] sum;
   logic [CW:0] wrapped;

   always_comb begin
      sum     = (CW+1)'(head) + (CW+1)'(pos);
      wrapped = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
      slot    = AW'(wrapped);
   end

endmodule
